// ----- rtl/vra_pkg.sv -----
// shared types and constants of the virtual space range allocator
package vra_pkg;

	// fixed field widths
	localparam int DATA_W    = 32;
	localparam int SIZE_W    = 33;
	localparam int SLOT_W    = 6;
	localparam int CFG_IDX_W = 2;
	localparam int SLOT_LIMIT = 1 << SLOT_W;

	// operation codes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_BAD_SIZE  = 2'd2;
	localparam logic [1:0] ST_BAD_SLOT  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_BEGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPACE_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_START = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE  = 2'd3;

	// configuration reset values
	localparam logic [DATA_W-1:0] SPACE_BEGIN_RST = 32'h0040_0000;
	localparam logic [DATA_W-1:0] SPACE_END_RST   = 32'hE000_0000;
	localparam logic [DATA_W-1:0] IMAGE_START_RST = 32'h0000_0000;
	localparam logic [DATA_W-1:0] IMAGE_SIZE_RST  = 32'h0000_0000;

	// sequencer states
	localparam int STATE_W = 3;
	localparam logic [STATE_W-1:0] S_IDLE  = 3'd0;
	localparam logic [STATE_W-1:0] S_CHECK = 3'd1;
	localparam logic [STATE_W-1:0] S_WALK  = 3'd2;
	localparam logic [STATE_W-1:0] S_LINK1 = 3'd3;
	localparam logic [STATE_W-1:0] S_LINK2 = 3'd4;
	localparam logic [STATE_W-1:0] S_RESP  = 3'd5;

	// page-rounded size limits of one request
	typedef struct packed {
		logic [SIZE_W-1:0] min_b;
		logic [SIZE_W-1:0] goal_b;
		logic [SIZE_W-1:0] max_b;
		logic              req_zero;
	} lim_t;

endpackage

// ----- rtl/vra_size_round.sv -----
// rounds a requested byte size into min, goal and max page multiples
module vra_size_round #(
	parameter int PAGE_BYTES = 4096
) (
	input  logic [vra_pkg::DATA_W-1:0] request_size,
	output vra_pkg::lim_t              lim
);
	import vra_pkg::*;

	localparam logic [SIZE_W-1:0] PAGE_MASK = SIZE_W'(PAGE_BYTES - 1);

	logic [SIZE_W-1:0] half;
	logic [SIZE_W-1:0] whole;
	logic [SIZE_W-1:0] twice;

	assign half  = {2'b00, request_size[DATA_W-1:1]};
	assign whole = {1'b0, request_size};
	assign twice = {request_size, 1'b0};

	// min rounds half plus one up, goal rounds up, max rounds twice down
	assign lim.min_b    = (half + SIZE_W'(1) + PAGE_MASK) & ~PAGE_MASK;
	assign lim.goal_b   = (whole + PAGE_MASK) & ~PAGE_MASK;
	assign lim.max_b    = twice & ~PAGE_MASK;
	assign lim.req_zero = (request_size == '0);

endmodule

// ----- rtl/vspace_region_allocator.sv -----
// virtual address range allocator over an address-ordered zone list
//
// The request channel (req_valid/req_stall) carries one word: op, slot and
// request_size. An allocate links a new zone for the slot after the first gap
// whose size lies within the page-rounded [min,max] window, or else splits the
// smallest larger gap at the goal size. A free unlinks the slot's zone.
// The response channel (rsp_valid/rsp_stall) returns one word per request:
// status, granted_size and region_base.
// A free or a rejected request passes from S_CHECK to S_RESP; an allocate walks
// the list in S_WALK, then links its zone in S_LINK1 and S_LINK2 before S_RESP.
// The list walk reads one zone per cycle through the zone memories' single read
// port. One request is in work at a time: req_stall is high from acceptance
// until the answer sits in the output register.
// A stalled response holds its word; a new request may be taken meanwhile, and
// its answer waits in the sequencer until the output register drains.
// Reset empties the list to root and image zones, frees all slots and loads the
// register defaults. Configuration writes go through cfg_we; the user makes them
// only while the block is idle, which the block itself does not enforce.
module vspace_region_allocator #(
	parameter int MAX_ZONES  = 64,
	parameter int PAGE_BYTES = 4096,
	parameter int TABLE_SPAN = 4194304
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vra_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          op,
	input  logic [vra_pkg::SLOT_W-1:0]    slot,
	input  logic [vra_pkg::DATA_W-1:0]    request_size,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic [vra_pkg::DATA_W-1:0]    granted_size,
	output logic [vra_pkg::DATA_W-1:0]    region_base
);
	import vra_pkg::*;

	// only slots reachable by the slot field get storage
	localparam int SLOTS = (MAX_ZONES < SLOT_LIMIT) ? MAX_ZONES : SLOT_LIMIT;
	localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int LW    = $clog2(SLOTS + 3);
	localparam logic [LW-1:0] ROOT_IX  = LW'(SLOTS);
	localparam logic [LW-1:0] IMAGE_IX = LW'(SLOTS + 1);
	localparam logic [LW-1:0] NIL_IX   = LW'(SLOTS + 2);
	localparam logic [DATA_W-1:0] SPAN_MASK = DATA_W'(TABLE_SPAN - 1);
	localparam logic [DATA_W-1:0] PAGE_W    = DATA_W'(PAGE_BYTES);

	typedef logic [LW-1:0] link_t;

	function automatic logic is_slot(input link_t x);
		return x < ROOT_IX;
	endfunction

	// sequencer and configuration
	logic [STATE_W-1:0] state_q;
	logic [DATA_W-1:0]  space_begin_q;
	logic [DATA_W-1:0]  space_end_q;
	logic [DATA_W-1:0]  image_start_q;
	logic [DATA_W-1:0]  image_size_q;
	logic [DATA_W-1:0]  image_base;
	logic [DATA_W-1:0]  image_used_q;

	// request
	logic              op_q;
	logic [SLOT_W-1:0] slot_q;
	lim_t              lim;
	lim_t              lim_q;
	logic [SW-1:0]     slot_ix;
	link_t             slot_link;
	logic              slot_ok;
	logic              slot_busy;
	logic              bad_size;
	logic              free_ok;
	logic              alloc_go;

	// list links of the fixed zones and slot occupancy
	link_t            root_next_q;
	link_t            image_next_q;
	logic [SLOTS-1:0] in_use_q;

	// zone memories
	logic [DATA_W-1:0] base_mem [SLOTS];
	logic [DATA_W-1:0] used_mem [SLOTS];
	link_t             next_mem [SLOTS];
	link_t             prev_mem [SLOTS];
	logic [SW-1:0]     rd_addr;
	logic [DATA_W-1:0] rd_base_q;
	logic [DATA_W-1:0] rd_used_q;
	link_t             rd_next_q;
	link_t             rd_prev_q;
	logic              zone_we;
	logic              next_we;
	logic [SW-1:0]     next_wa;
	link_t             next_wd;
	logic              prev_we;
	logic [SW-1:0]     prev_wa;
	link_t             prev_wd;

	// list walk
	link_t             cur_q;
	logic [DATA_W-1:0] cur_used_q;
	link_t             nx_q;
	logic              cur_valid;
	logic              n_is_img;
	logic              n_valid;
	logic [DATA_W-1:0] n_base;
	logic [DATA_W-1:0] n_used;
	link_t             n_next;
	logic [DATA_W-1:0] gap_end;
	logic [DATA_W-1:0] gap;
	logic              v_s1;
	logic [DATA_W-1:0] gap_s1;
	link_t             from_s1;
	logic [DATA_W-1:0] fused_s1;
	link_t             fnext_s1;
	logic              in_window;
	logic              hit;
	logic              better;
	logic              walk_done;
	logic              best_valid_q;
	logic [DATA_W-1:0] best_size_q;
	link_t             best_from_q;
	logic [DATA_W-1:0] best_used_q;
	link_t             best_next_q;

	// link target
	link_t             lk_from_q;
	logic [DATA_W-1:0] lk_used_q;
	link_t             lk_next_q;
	logic [DATA_W-1:0] lk_size_q;

	// result and output register
	logic [1:0]        res_status_q;
	logic [DATA_W-1:0] res_size_q;
	logic [DATA_W-1:0] res_base_q;
	logic              rsp_valid_q;
	logic              out_free;
	logic [1:0]        status_q;
	logic [DATA_W-1:0] granted_q;
	logic [DATA_W-1:0] base_q;

	vra_size_round #(
		.PAGE_BYTES (PAGE_BYTES)
	) u_size_round (
		.request_size (request_size),
		.lim          (lim)
	);

	// handshake
	assign req_stall    = (state_q != S_IDLE);
	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign granted_size = granted_q;
	assign region_base  = base_q;
	assign out_free     = !rsp_valid_q || !rsp_stall;

	// request checks
	assign slot_ix   = slot_q[SW-1:0];
	assign slot_link = LW'(slot_ix);
	assign slot_ok   = (7'(slot_q) < 7'(SLOTS));
	assign slot_busy = in_use_q[slot_ix];
	assign bad_size  = lim_q.req_zero || (lim_q.max_b < lim_q.goal_b);
	assign free_ok   = slot_ok && (op_q == OP_FREE) && slot_busy;
	assign alloc_go  = slot_ok && (op_q == OP_ALLOC) && !slot_busy && !bad_size;

	// image zone base
	assign image_base = image_start_q & ~SPAN_MASK;

	// next zone fields, from memory or from the fixed image zone
	assign cur_valid = (cur_q != NIL_IX);
	assign n_is_img  = (nx_q == IMAGE_IX);
	assign n_valid   = (nx_q != NIL_IX);
	assign n_base    = n_is_img ? image_base : rd_base_q;
	assign n_used    = n_is_img ? image_used_q : rd_used_q;
	assign n_next    = n_is_img ? image_next_q : rd_next_q;

	// gap of the current zone, reversed gaps count as empty
	assign gap_end = n_valid ? n_base : space_end_q;
	assign gap     = (gap_end > cur_used_q) ? (gap_end - cur_used_q) : '0;

	// fit decision on the registered gap
	assign in_window = v_s1 && ({1'b0, gap_s1} >= lim_q.min_b);
	assign hit       = in_window && ({1'b0, gap_s1} <= lim_q.max_b);
	assign better    = in_window && !hit && (!best_valid_q || (gap_s1 < best_size_q));
	assign walk_done = !cur_valid && !v_s1;

	// read address of the zone memories
	always_comb begin
		case (state_q)
			S_IDLE:  rd_addr = slot[SW-1:0];
			S_CHECK: rd_addr = root_next_q[SW-1:0];
			S_WALK:  rd_addr = n_next[SW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// write ports of the zone memories
	always_comb begin
		zone_we = 1'b0;
		next_we = 1'b0;
		next_wa = '0;
		next_wd = NIL_IX;
		prev_we = 1'b0;
		prev_wa = '0;
		prev_wd = NIL_IX;
		case (state_q)
			S_CHECK: begin
				if (free_ok) begin
					if (is_slot(rd_prev_q)) begin
						next_we = 1'b1;
						next_wa = rd_prev_q[SW-1:0];
						next_wd = rd_next_q;
					end
					if (is_slot(rd_next_q)) begin
						prev_we = 1'b1;
						prev_wa = rd_next_q[SW-1:0];
						prev_wd = rd_prev_q;
					end
				end
			end
			S_LINK1: begin
				zone_we = 1'b1;
				next_we = 1'b1;
				next_wa = slot_ix;
				next_wd = lk_next_q;
				prev_we = 1'b1;
				prev_wa = slot_ix;
				prev_wd = lk_from_q;
			end
			S_LINK2: begin
				if (is_slot(lk_from_q)) begin
					next_we = 1'b1;
					next_wa = lk_from_q[SW-1:0];
					next_wd = slot_link;
				end
				if (is_slot(lk_next_q)) begin
					prev_we = 1'b1;
					prev_wa = lk_next_q[SW-1:0];
					prev_wd = slot_link;
				end
			end
			default: begin
				zone_we = 1'b0;
			end
		endcase
	end

	// zone base and used-end memories
	always_ff @(posedge clk) begin
		if (zone_we) begin
			base_mem[slot_ix] <= lk_used_q;
			used_mem[slot_ix] <= lk_used_q + lk_size_q;
		end
		rd_base_q <= base_mem[rd_addr];
		rd_used_q <= used_mem[rd_addr];
	end

	// forward link memory
	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		rd_next_q <= next_mem[rd_addr];
	end

	// backward link memory
	always_ff @(posedge clk) begin
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		rd_prev_q <= prev_mem[rd_addr];
	end

	// sequencer, configuration, fixed links and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			space_begin_q <= SPACE_BEGIN_RST;
			space_end_q   <= SPACE_END_RST;
			image_start_q <= IMAGE_START_RST;
			image_size_q  <= IMAGE_SIZE_RST;
			root_next_q   <= IMAGE_IX;
			image_next_q  <= NIL_IX;
			in_use_q      <= '0;
			v_s1          <= 1'b0;
			best_valid_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPACE_BEGIN: space_begin_q <= cfg_data;
					CFG_SPACE_END:   space_end_q   <= cfg_data;
					CFG_IMAGE_START: image_start_q <= cfg_data;
					CFG_IMAGE_SIZE:  image_size_q  <= cfg_data;
					default:         space_begin_q <= space_begin_q;
				endcase
			end
			// output word valid: loaded from the sequencer, dropped when taken
			if ((state_q == S_RESP) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					v_s1         <= 1'b0;
					best_valid_q <= 1'b0;
					if (free_ok) begin
						if (rd_prev_q == ROOT_IX) begin
							root_next_q <= rd_next_q;
						end
						if (rd_prev_q == IMAGE_IX) begin
							image_next_q <= rd_next_q;
						end
						in_use_q[slot_ix] <= 1'b0;
						state_q <= S_RESP;
					end else if (alloc_go) begin
						state_q <= S_WALK;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_WALK: begin
					v_s1 <= cur_valid;
					if (better) begin
						best_valid_q <= 1'b1;
					end
					if (hit) begin
						state_q <= S_LINK1;
					end else if (walk_done) begin
						state_q <= best_valid_q ? S_LINK1 : S_RESP;
					end
				end
				S_LINK1: begin
					in_use_q[slot_ix] <= 1'b1;
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					if (lk_from_q == ROOT_IX) begin
						root_next_q <= slot_link;
					end
					if (lk_from_q == IMAGE_IX) begin
						image_next_q <= slot_link;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		image_used_q <= (image_start_q + image_size_q + PAGE_W + SPAN_MASK) & ~SPAN_MASK;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					op_q   <= op;
					slot_q <= slot;
					lim_q  <= lim;
				end
			end
			S_CHECK: begin
				res_size_q <= '0;
				res_base_q <= '0;
				cur_q      <= ROOT_IX;
				cur_used_q <= space_begin_q;
				nx_q       <= root_next_q;
				if (!slot_ok) begin
					res_status_q <= ST_BAD_SLOT;
				end else if (op_q == OP_FREE) begin
					res_status_q <= slot_busy ? ST_OK : ST_BAD_SLOT;
				end else if (slot_busy) begin
					res_status_q <= ST_BAD_SLOT;
				end else if (bad_size) begin
					res_status_q <= ST_BAD_SIZE;
				end else begin
					res_status_q <= ST_OK;
				end
			end
			S_WALK: begin
				// advance one zone along the list
				if (cur_valid) begin
					gap_s1     <= gap;
					from_s1    <= cur_q;
					fused_s1   <= cur_used_q;
					fnext_s1   <= nx_q;
					cur_q      <= nx_q;
					cur_used_q <= n_used;
					nx_q       <= n_next;
				end
				// remember the smallest oversized gap
				if (better) begin
					best_size_q <= gap_s1;
					best_from_q <= from_s1;
					best_used_q <= fused_s1;
					best_next_q <= fnext_s1;
				end
				if (hit) begin
					lk_from_q <= from_s1;
					lk_used_q <= fused_s1;
					lk_next_q <= fnext_s1;
					lk_size_q <= gap_s1;
				end else if (walk_done) begin
					lk_from_q <= best_from_q;
					lk_used_q <= best_used_q;
					lk_next_q <= best_next_q;
					lk_size_q <= lim_q.goal_b[DATA_W-1:0];
					if (!best_valid_q) begin
						res_status_q <= ST_EXHAUSTED;
					end
				end
			end
			S_LINK1: begin
				res_status_q <= ST_OK;
				res_size_q   <= lk_size_q;
				res_base_q   <= lk_used_q;
			end
			S_RESP: begin
				if (out_free) begin
					status_q  <= res_status_q;
					granted_q <= res_size_q;
					base_q    <= res_base_q;
				end
			end
			default: begin
				res_status_q <= res_status_q;
			end
		endcase
	end

endmodule

// ----- verif/vra_grant_checker.sv -----
// watches the allocator channels, predicts every answer word and compares it
module vra_grant_checker #(
	parameter int MAX_ZONES  = 64,
	parameter int PAGE_BYTES = 4096,
	parameter int TABLE_SPAN = 4194304
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [vra_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vra_pkg::DATA_W-1:0]    cfg_data,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic                          op,
	input  logic [vra_pkg::SLOT_W-1:0]    slot,
	input  logic [vra_pkg::DATA_W-1:0]    request_size,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [1:0]                    status,
	input  logic [vra_pkg::DATA_W-1:0]    granted_size,
	input  logic [vra_pkg::DATA_W-1:0]    region_base,
	output int                            fail_count,
	output int                            words_pending,
	output logic [MAX_ZONES-1:0]          slot_busy
);
	import vra_pkg::*;

	// zone table layout: slots first, then the list head and image zones
	localparam int HEAD_ZONE  = MAX_ZONES;
	localparam int IMAGE_ZONE = MAX_ZONES + 1;
	localparam int ZONE_TOTAL = MAX_ZONES + 2;
	localparam int LINK_W     = $clog2(ZONE_TOTAL + 1);
	localparam logic [LINK_W-1:0] NO_LINK = {LINK_W{1'b1}};

	typedef logic [SIZE_W-1:0] span_t;
	localparam span_t PAGE_MASK = span_t'(PAGE_BYTES - 1);
	localparam logic [DATA_W-1:0] SPAN_MASK = DATA_W'(TABLE_SPAN - 1);

	typedef struct packed {
		logic [1:0]        status;
		logic [DATA_W-1:0] granted;
		logic [DATA_W-1:0] base;
	} grant_t;

	// shadow registers and zone list
	logic [DATA_W-1:0] space_begin_q, space_end_q, image_start_q, image_size_q;
	logic [DATA_W-1:0] zone_lo [ZONE_TOTAL];
	logic [DATA_W-1:0] zone_top [ZONE_TOTAL];
	logic [LINK_W-1:0] fwd [ZONE_TOTAL];
	logic [LINK_W-1:0] back [ZONE_TOTAL];
	logic [MAX_ZONES-1:0] busy;

	grant_t pending_grants[$];
	grant_t want_word;
	int     mismatches;

	// head and image zones track the registers at once
	task automatic refresh_fixed_zones();
		logic [DATA_W-1:0] img_end;
		img_end = image_start_q + image_size_q + DATA_W'(PAGE_BYTES) + SPAN_MASK;
		zone_lo[HEAD_ZONE]   = space_begin_q;
		zone_top[HEAD_ZONE]  = space_begin_q;
		zone_lo[IMAGE_ZONE]  = image_start_q & ~SPAN_MASK;
		zone_top[IMAGE_ZONE] = img_end & ~SPAN_MASK;
	endtask

	// free bytes behind a zone, zero when the gap is reversed
	function automatic span_t gap_size(int ix);
		logic [LINK_W-1:0] nx;
		logic [DATA_W-1:0] stop;
		nx = fwd[ix];
		stop = (nx < ZONE_TOTAL) ? zone_lo[nx] : space_end_q;
		return (stop > zone_top[ix]) ? {1'b0, stop - zone_top[ix]} : '0;
	endfunction

	// insert a zone of the given size right after another
	task automatic link_zone(int from, int to, span_t sz);
		logic [LINK_W-1:0] nx;
		nx = fwd[from];
		fwd[to]      = nx;
		back[to]     = LINK_W'(from);
		zone_lo[to]  = zone_top[from];
		zone_top[to] = zone_lo[to] + sz[DATA_W-1:0];
		fwd[from]    = LINK_W'(to);
		if (nx < ZONE_TOTAL) back[nx] = LINK_W'(to);
	endtask

	// answer word of one request, applied to the shadow list
	task automatic predict_grant(input logic op_i, input logic [SLOT_W-1:0] slot_i,
			input logic [DATA_W-1:0] req, output grant_t g);
		span_t req_w, lo, goal, hi, sz, best_sz;
		int z, cur, best, steps;
		logic [LINK_W-1:0] pv, nx;
		bit done;
		g = '{status: ST_OK, granted: '0, base: '0};
		z = slot_i;
		req_w = {1'b0, req};
		best_sz = '0;
		if (z >= MAX_ZONES) begin
			g.status = ST_BAD_SLOT;
		end else if (op_i == OP_FREE) begin
			if (!busy[z]) begin
				g.status = ST_BAD_SLOT;
			end else begin
				pv = back[z];
				nx = fwd[z];
				if (pv < ZONE_TOTAL) fwd[pv] = nx;
				if (nx < ZONE_TOTAL) back[nx] = pv;
				fwd[z]  = NO_LINK;
				back[z] = NO_LINK;
				busy[z] = 1'b0;
			end
		end else if (busy[z]) begin
			g.status = ST_BAD_SLOT;
		end else begin
			lo   = ((req_w >> 1) + 1 + PAGE_MASK) & ~PAGE_MASK;
			goal = (req_w + PAGE_MASK) & ~PAGE_MASK;
			hi   = (req_w << 1) & ~PAGE_MASK;
			if (req == '0 || hi < goal) begin
				g.status = ST_BAD_SIZE;
			end else begin
				// first gap inside the window wins, else the smallest larger one
				cur = HEAD_ZONE;
				best = -1;
				done = 1'b0;
				for (steps = 0; steps < ZONE_TOTAL && cur < ZONE_TOTAL && !done; steps++) begin
					sz = gap_size(cur);
					if (sz >= lo) begin
						if (sz <= hi) begin
							link_zone(cur, z, sz);
							busy[z] = 1'b1;
							g.granted = sz[DATA_W-1:0];
							g.base = zone_lo[z];
							done = 1'b1;
						end else if (best < 0 || sz < best_sz) begin
							best = cur;
							best_sz = sz;
						end
					end
					if (!done) cur = fwd[cur];
				end
				if (!done) begin
					if (best < 0) begin
						g.status = ST_EXHAUSTED;
					end else begin
						link_zone(best, z, goal);
						busy[z] = 1'b1;
						g.granted = goal[DATA_W-1:0];
						g.base = zone_lo[z];
					end
				end
			end
		end
	endtask

	// register writes, answer checks and request predictions
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			space_begin_q = SPACE_BEGIN_RST;
			space_end_q   = SPACE_END_RST;
			image_start_q = IMAGE_START_RST;
			image_size_q  = IMAGE_SIZE_RST;
			for (int i = 0; i < ZONE_TOTAL; i++) begin
				zone_lo[i]  = '0;
				zone_top[i] = '0;
				fwd[i]      = NO_LINK;
				back[i]     = NO_LINK;
			end
			fwd[HEAD_ZONE]   = LINK_W'(IMAGE_ZONE);
			back[IMAGE_ZONE] = LINK_W'(HEAD_ZONE);
			busy = '0;
			refresh_fixed_zones();
			pending_grants.delete();
			mismatches = 0;
			fail_count    <= 0;
			words_pending <= 0;
			slot_busy     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SPACE_BEGIN: space_begin_q = cfg_data;
					CFG_SPACE_END:   space_end_q   = cfg_data;
					CFG_IMAGE_START: image_start_q = cfg_data;
					CFG_IMAGE_SIZE:  image_size_q  = cfg_data;
					default: ;
				endcase
				refresh_fixed_zones();
			end
			// answer word against the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (pending_grants.size() == 0) begin
					$display("%0t: answer word with none expected: status %0d size %h base %h",
						$time, status, granted_size, region_base);
					mismatches++;
				end else begin
					want_word = pending_grants.pop_front();
					if (status !== want_word.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want_word.status, status);
						mismatches++;
					end
					if (granted_size !== want_word.granted) begin
						$display("%0t: granted_size expected %h actual %h",
							$time, want_word.granted, granted_size);
						mismatches++;
					end
					if (region_base !== want_word.base) begin
						$display("%0t: region_base expected %h actual %h",
							$time, want_word.base, region_base);
						mismatches++;
					end
				end
			end
			// request word accepted
			if (req_valid && !req_stall) begin
				predict_grant(op, slot, request_size, want_word);
				pending_grants.push_back(want_word);
			end
			fail_count    <= mismatches;
			words_pending <= pending_grants.size();
			slot_busy     <= busy;
		end
	end

endmodule

// ----- verif/vspace_region_allocator_tb.sv -----
// stimulus and verdict for the virtual space range allocator
module vspace_region_allocator_tb;
	import vra_pkg::*;

	localparam int MAX_ZONES   = 64;
	localparam int PAGE_BYTES  = 4096;
	localparam int TABLE_SPAN  = 4194304;
	localparam int PHASES      = 8;
	localparam int PHASE_WORDS = 160;
	localparam int LONG_HOLD   = 400;
	localparam int END_WAIT    = 80;
	localparam int CYCLE_LIMIT = 1000000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 op = OP_ALLOC;
	logic [SLOT_W-1:0]    slot = '0;
	logic [DATA_W-1:0]    request_size = '0;
	logic                 rsp_stall = 1'b0;
	logic                 req_stall;
	logic                 rsp_valid;
	logic [1:0]           status;
	logic [DATA_W-1:0]    granted_size;
	logic [DATA_W-1:0]    region_base;

	int                   fail_count;
	int                   words_pending;
	logic [MAX_ZONES-1:0] slot_busy;

	bit calm = 1'b0;
	bit long_hold_req = 1'b0;
	int cycles = 0;

	vspace_region_allocator #(
		.MAX_ZONES(MAX_ZONES), .PAGE_BYTES(PAGE_BYTES), .TABLE_SPAN(TABLE_SPAN)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .slot(slot), .request_size(request_size),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .granted_size(granted_size), .region_base(region_base)
	);

	vra_grant_checker #(
		.MAX_ZONES(MAX_ZONES), .PAGE_BYTES(PAGE_BYTES), .TABLE_SPAN(TABLE_SPAN)
	) chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.req_valid(req_valid), .req_stall(req_stall),
		.op(op), .slot(slot), .request_size(request_size),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .granted_size(granted_size), .region_base(region_base),
		.fail_count(fail_count), .words_pending(words_pending), .slot_busy(slot_busy)
	);

	// clock
	initial begin
		forever #5 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("vspace_region_allocator_tb: FAIL");
			$finish;
		end
	end

	// idle cycles before one word, none in calm stretches
	function automatic int pause_len();
		return calm ? 0 : $urandom_range(14, 0);
	endfunction

	// offer one request word and hold it until taken
	task automatic send_word(input logic o, input logic [SLOT_W-1:0] s,
			input logic [DATA_W-1:0] sz);
		int gap;
		gap = pause_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid    <= 1'b1;
		op           <= o;
		slot         <= s;
		request_size <= sz;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// stop offering and wait until every answer word is back
	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (words_pending == 0);
		@(posedge clk);
	endtask

	// write all four registers, block idle
	task automatic load_config(input logic [DATA_W-1:0] b, e, s, z);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SPACE_BEGIN;
		cfg_data  <= b;
		@(posedge clk);
		cfg_index <= CFG_SPACE_END;
		cfg_data  <= e;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_START;
		cfg_data  <= s;
		@(posedge clk);
		cfg_index <= CFG_IMAGE_SIZE;
		cfg_data  <= z;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// free every slot that holds a zone
	task automatic release_all();
		for (int s = 0; s < MAX_ZONES; s++)
			if (slot_busy[s]) send_word(OP_FREE, SLOT_W'(s), $urandom());
	endtask

	// request sizes: mostly a few pages, some powers of two, wide and extreme values
	function automatic logic [DATA_W-1:0] pick_size(int pages_cap);
		int kind;
		kind = $urandom_range(99, 0);
		if (kind < 60)
			return DATA_W'($urandom_range(pages_cap, 1) * PAGE_BYTES - $urandom_range(PAGE_BYTES - 1, 0));
		if (kind < 75)
			return (32'h1 << $urandom_range(31, 0)) + DATA_W'($urandom_range(255, 0)) - 32'd128;
		if (kind < 90)
			return $urandom();
		if (kind < 95)
			return DATA_W'($urandom_range(8191, 0));
		case ($urandom_range(5, 0))
			0: return 32'h0;
			1: return 32'h1;
			2: return 32'hFFFF_FFFF;
			3: return 32'h8000_0000;
			4: return 32'h0000_0800;
			default: return 32'hFFFF_F000;
		endcase
	endfunction

	// mostly a slot that makes the operation well formed
	function automatic logic [SLOT_W-1:0] pick_slot(input logic o);
		logic [SLOT_W-1:0] s;
		s = SLOT_W'($urandom_range(MAX_ZONES - 1, 0));
		if ($urandom_range(99, 0) < 85) begin
			for (int tries = 0; tries < 12; tries++) begin
				if ((o == OP_ALLOC) != slot_busy[s]) break;
				s = SLOT_W'($urandom_range(MAX_ZONES - 1, 0));
			end
		end
		return s;
	endfunction

	// answer side: random stalls, one long hold on request
	initial begin : rsp_side
		int hold;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				hold = LONG_HOLD;
				long_hold_req = 1'b0;
			end else begin
				hold = pause_len();
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
		end
	end

	// request side
	initial begin : req_side
		logic [DATA_W-1:0] b, e, s, z;
		logic o;
		int cap;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words on the reset list: root gap reversed, image gap up to space end
		send_word(OP_ALLOC, 6'd0, 32'h0);
		send_word(OP_ALLOC, 6'd0, 32'h1);
		send_word(OP_ALLOC, 6'd0, 32'hFFFF_FFFF);
		send_word(OP_ALLOC, 6'd1, 32'h0000_1000);
		send_word(OP_ALLOC, 6'd0, 32'h0000_1000);
		send_word(OP_FREE, 6'd0, 32'h0);
		send_word(OP_FREE, 6'd0, 32'hFFFF_FFFF);
		send_word(OP_FREE, 6'd63, 32'h0);
		send_word(OP_ALLOC, 6'd63, 32'h0000_2000);
		send_word(OP_ALLOC, 6'd1, 32'h0000_1800);
		send_word(OP_ALLOC, 6'd2, 32'h0000_3000);
		send_word(OP_FREE, 6'd1, 32'h0);
		send_word(OP_ALLOC, 6'd3, 32'h0000_1000);
		send_word(OP_ALLOC, 6'd4, 32'h7FFF_FFFF);
		send_word(OP_ALLOC, 6'd5, 32'h8000_0000);
		send_word(OP_ALLOC, 6'd6, 32'h0000_1000);
		send_word(OP_ALLOC, 6'd7, 32'h0000_0800);
		send_word(OP_FREE, 6'd4, 32'h0);
		send_word(OP_FREE, 6'd5, 32'h0);
		send_word(OP_FREE, 6'd63, 32'h0);
		send_word(OP_FREE, 6'd2, 32'h0);
		send_word(OP_FREE, 6'd3, 32'h0);
		send_word(OP_FREE, 6'd7, 32'h0);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			if (p == 1 || p == 4) begin
				release_all();
				drain();
			end
			case (p)
				0: begin
					b = SPACE_BEGIN_RST; e = SPACE_END_RST;
					s = IMAGE_START_RST; z = IMAGE_SIZE_RST; cap = 64;
				end
				1: begin
					// narrow window of 128 pages behind the image zone
					b = 32'h1000_0000; e = 32'h1048_0000;
					s = 32'h1000_0000; z = 32'h0; cap = 16;
				end
				2: begin
					b = 32'hFFFF_FFFF; e = 32'hFFFF_FFFF;
					s = 32'hFFFF_FFFF; z = 32'hFFFF_FFFF; cap = 4096;
				end
				3: begin
					b = 32'h0; e = 32'h0; s = 32'h0; z = 32'h0; cap = 8;
				end
				4: begin
					b = 32'h0; e = 32'h0060_0000;
					s = 32'h0010_0000; z = 32'h0000_1000; cap = 64;
				end
				6: begin
					b = $urandom() & 32'hFFC0_0000;
					s = b;
					z = DATA_W'($urandom_range(32'h00FF_FFFF, 0));
					e = b + 32'h0100_0000 + ($urandom() & 32'h00FF_F000);
					cap = 256;
				end
				default: begin
					b = $urandom(); e = $urandom(); s = $urandom(); z = $urandom();
					cap = 1024;
				end
			endcase
			load_config(b, e, s, z);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if ((p == 0 || p == 6) && i == 0) calm = 1'b1;
				if ((p == 0 || p == 6) && i == 40) calm = 1'b0;
				// long answer hold while words keep coming
				if (p == 2 && i == 40) begin
					long_hold_req = 1'b1;
					calm = 1'b1;
				end
				if (p == 2 && i == 70) calm = 1'b0;
				if (p == 5 && i == 80) drain();
				o = ($urandom_range(99, 0) < 58) ? OP_ALLOC : OP_FREE;
				send_word(o, pick_slot(o), pick_size(cap));
			end
			drain();
		end

		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("vspace_region_allocator_tb: PASS");
		else
			$display("vspace_region_allocator_tb: FAIL");
		$finish;
	end

endmodule
